@@ sv/bdphr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdphr_pkg: shared definitions for the button debouncer
// Register indexes, field widths, the button state type and its output code.
// ----------------------------------------------------------------------------
package bdphr_pkg;

   localparam int unsigned TickWidth    = 16;
   localparam int unsigned ElapsedWidth = 17;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CodeWidth    = 2;

   localparam logic [ElapsedWidth-1:0] ElapsedMax = {ElapsedWidth{1'b1}};

   localparam logic [CsrIdxWidth-1:0] CSR_ACTIVE_LOW     = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_DEBOUNCE_TICKS = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_HOLD_TICKS     = 2'd2;

   localparam logic [TickWidth-1:0] DebounceReset = 16'd50;
   localparam logic [TickWidth-1:0] HoldReset     = 16'd1000;

   localparam logic [CodeWidth-1:0] CODE_UNPRESSED = 2'd0;
   localparam logic [CodeWidth-1:0] CODE_PRESSED   = 2'd1;
   localparam logic [CodeWidth-1:0] CODE_RELEASED  = 2'd2;
   localparam logic [CodeWidth-1:0] CODE_HELD      = 2'd3;

   typedef enum logic [3:0] {
      ST_UNPRESSED = 4'b0001,
      ST_PRESSED   = 4'b0010,
      ST_RELEASED  = 4'b0100,
      ST_HELD      = 4'b1000
   } button_state_type;

   function automatic logic [CodeWidth-1:0] encode_state(input button_state_type st);
      logic [CodeWidth-1:0] code;
      case (st)
         ST_UNPRESSED: code = CODE_UNPRESSED;
         ST_PRESSED:   code = CODE_PRESSED;
         ST_RELEASED:  code = CODE_RELEASED;
         ST_HELD:      code = CODE_HELD;
         default:      code = CODE_UNPRESSED;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

@@ sv/button_debounce_press_hold_release_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_press_hold_release_top: debounced button with long press
// One request per millisecond tick carries the raw pin level; every request
// yields one response with the button state and its decoded flags.
//
// Request channel req_valid/req_ready with req_pin_level. Response channel
// rsp_valid/rsp_ready with rsp_button_state (0 unpressed, 1 pressed,
// 2 released, 3 held) and the is_pressed/is_released/is_held flags.
// csr_we/csr_index/csr_wdata writes active_low, debounce_ticks, hold_ticks.
//
// The state update happens at the accepting edge and the response is in
// the output register on the next cycle. The block takes one request per
// cycle as long as the receiver keeps taking the responses.
// req_ready stays high while the output register is empty or being taken;
// a stalled receiver holds the response and blocks only the next request.
// Synchronous reset clears the state to unpressed, the pending flag and the
// elapsed counter, and restores the register defaults.
// ----------------------------------------------------------------------------
module button_debounce_press_hold_release_top (
   input  wire  logic                              clock,
   input  wire  logic                              reset,
   input  wire  logic                              req_valid,
   output logic                                    req_ready,
   input  wire  logic                              req_pin_level,
   output logic                                    rsp_valid,
   input  wire  logic                              rsp_ready,
   output logic [bdphr_pkg::CodeWidth-1:0]         rsp_button_state,
   output logic                                    rsp_is_pressed,
   output logic                                    rsp_is_released,
   output logic                                    rsp_is_held,
   input  wire  logic                              csr_we,
   input  wire  logic [bdphr_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire  logic [bdphr_pkg::TickWidth-1:0]   csr_wdata
);

   logic                                   active_low_ff;
   logic [bdphr_pkg::TickWidth-1:0]        debounce_ff;
   logic [bdphr_pkg::TickWidth-1:0]        hold_ff;

   bdphr_pkg::button_state_type            state_ff, state_in;
   logic                                   pending_ff, pending_in;
   logic [bdphr_pkg::ElapsedWidth-1:0]     elapsed_ff, elapsed_in, elapsed_inc;

   logic                                   rsp_valid_ff;
   logic [bdphr_pkg::CodeWidth-1:0]        rsp_code_ff;

   logic req_fire;
   logic level;
   logic debounce_done;
   logic hold_done;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign level     = req_pin_level ^ active_low_ff;

   assign elapsed_inc = (elapsed_ff == bdphr_pkg::ElapsedMax) ? elapsed_ff
                        : elapsed_ff + 1'b1;
   assign debounce_done = elapsed_inc > {1'b0, debounce_ff};
   assign hold_done     = elapsed_inc > {1'b0, hold_ff};

   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      elapsed_in = elapsed_inc;
      if (pending_ff && debounce_done) begin
         // timer expired: confirm if the level still calls for it
         pending_in = 1'b0;
         if (level && state_ff == bdphr_pkg::ST_UNPRESSED) begin
            state_in = bdphr_pkg::ST_PRESSED;
         end else if (!level && (state_ff == bdphr_pkg::ST_PRESSED ||
                                 state_ff == bdphr_pkg::ST_HELD)) begin
            state_in = bdphr_pkg::ST_RELEASED;
         end
      end else if (!pending_ff && !level && state_ff != bdphr_pkg::ST_UNPRESSED) begin
         if (state_ff == bdphr_pkg::ST_RELEASED) begin
            state_in = bdphr_pkg::ST_UNPRESSED;
         end else begin
            elapsed_in = '0;
            pending_in = 1'b1;
         end
      end else if (!pending_ff && level && state_ff == bdphr_pkg::ST_UNPRESSED) begin
         elapsed_in = '0;
         pending_in = 1'b1;
      end else if (state_ff == bdphr_pkg::ST_PRESSED && hold_done) begin
         state_in = bdphr_pkg::ST_HELD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_low_ff <= 1'b0;
         debounce_ff   <= bdphr_pkg::DebounceReset;
         hold_ff       <= bdphr_pkg::HoldReset;
      end else if (csr_we) begin
         case (csr_index)
            bdphr_pkg::CSR_ACTIVE_LOW:     active_low_ff <= csr_wdata[0];
            bdphr_pkg::CSR_DEBOUNCE_TICKS: debounce_ff   <= csr_wdata;
            bdphr_pkg::CSR_HOLD_TICKS:     hold_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bdphr_pkg::ST_UNPRESSED;
         pending_ff <= 1'b0;
         elapsed_ff <= '0;
      end else if (req_fire) begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_code_ff <= bdphr_pkg::encode_state(state_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_button_state = rsp_code_ff;
   assign rsp_is_pressed   = rsp_code_ff == bdphr_pkg::CODE_PRESSED ||
                             rsp_code_ff == bdphr_pkg::CODE_HELD;
   assign rsp_is_released  = rsp_code_ff == bdphr_pkg::CODE_RELEASED;
   assign rsp_is_held      = rsp_code_ff == bdphr_pkg::CODE_HELD;

`ifndef SYNTHESIS
   // accepted request always shows up as a response next cycle
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("response missing after accepted request");

   a_unpressed_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == bdphr_pkg::ST_UNPRESSED |=>
         (state_ff == bdphr_pkg::ST_UNPRESSED || state_ff == bdphr_pkg::ST_PRESSED))
      else $error("illegal transition out of unpressed");

   a_released_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == bdphr_pkg::ST_RELEASED |=>
         (state_ff == bdphr_pkg::ST_RELEASED || state_ff == bdphr_pkg::ST_UNPRESSED))
      else $error("illegal transition out of released");

   // arming the timer restarts the elapsed count
   a_arm_clears_count: assert property (@(posedge clock) disable iff (reset)
      $rose(pending_ff) |-> elapsed_ff == '0)
      else $error("elapsed count not cleared on arming");
`endif

endmodule
`default_nettype wire
